>>> rtl/qss_pkg.sv
// Shared types, reset values and helpers for the quoted string scanner.
// No dependencies; imported by the scanner modules.
`default_nettype none

package qss_pkg;

	localparam int QSS_MAX_QUOTE_LEN_DEF = 4;

	localparam int QSS_CHAR_W  = 8;
	localparam int QSS_CHARS_W = 32;
	localparam int QSS_LEN_W   = 3;
	localparam int QSS_IDX_W   = 3;
	localparam int QSS_QUOTE_BYTES = QSS_CHARS_W / QSS_CHAR_W;

	// Configuration register indexes
	localparam logic [QSS_IDX_W-1:0] REG_OPEN_CHARS  = 3'd0;
	localparam logic [QSS_IDX_W-1:0] REG_OPEN_LEN    = 3'd1;
	localparam logic [QSS_IDX_W-1:0] REG_CLOSE_CHARS = 3'd2;
	localparam logic [QSS_IDX_W-1:0] REG_CLOSE_LEN   = 3'd3;
	localparam logic [QSS_IDX_W-1:0] REG_ESCAPE_CODE = 3'd4;

	localparam logic [QSS_CHARS_W-1:0] OPEN_CHARS_RST  = 32'd34;
	localparam logic [QSS_LEN_W-1:0]   OPEN_LEN_RST    = 3'd1;
	localparam logic [QSS_CHARS_W-1:0] CLOSE_CHARS_RST = 32'd34;
	localparam logic [QSS_LEN_W-1:0]   CLOSE_LEN_RST   = 3'd1;
	localparam logic [QSS_CHAR_W-1:0]  ESCAPE_CODE_RST = 8'd92;

	// Escape letters and the control codes they stand for
	localparam logic [7:0] CH_N   = 8'h6E;
	localparam logic [7:0] CH_R   = 8'h72;
	localparam logic [7:0] CH_B   = 8'h62;
	localparam logic [7:0] CH_T   = 8'h74;
	localparam logic [7:0] CH_A   = 8'h61;
	localparam logic [7:0] CC_LF  = 8'h0A;
	localparam logic [7:0] CC_CR  = 8'h0D;
	localparam logic [7:0] CC_BS  = 8'h08;
	localparam logic [7:0] CC_HT  = 8'h09;
	localparam logic [7:0] CC_BEL = 8'h07;

	typedef struct packed {
		logic [QSS_CHARS_W-1:0] open_chars;
		logic [QSS_LEN_W-1:0]   open_len;
		logic [QSS_CHARS_W-1:0] close_chars;
		logic [QSS_LEN_W-1:0]   close_len;
		logic [QSS_CHAR_W-1:0]  escape_code;
	} qss_cfg_t;

	typedef struct packed {
		logic                  accepted;
		logic                  char_valid;
		logic [QSS_CHAR_W-1:0] out_char;
		logic                  opened;
		logic                  closed;
		logic                  escape_waiting;
	} qss_result_t;

	function automatic logic [QSS_CHAR_W-1:0] qss_translate(input logic [QSS_CHAR_W-1:0] c);
		logic [QSS_CHAR_W-1:0] r;
		unique case (c)
			CH_N:    r = CC_LF;
			CH_R:    r = CC_CR;
			CH_B:    r = CC_BS;
			CH_T:    r = CC_HT;
			CH_A:    r = CC_BEL;
			default: r = c;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/qss_if.sv
// Valid/ready channel interfaces for scanner input characters and result items.
// Depends on nothing.
`default_nettype none

interface qss_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       restart;

	modport source (output valid, output ch, output restart, input ready);
	modport sink (input valid, input ch, input restart, output ready);
endinterface

interface qss_out_if;
	logic       valid;
	logic       ready;
	logic       accepted;
	logic       char_valid;
	logic [7:0] out_char;
	logic       opened;
	logic       closed;
	logic       escape_waiting;

	modport source (output valid, output accepted, output char_valid, output out_char,
		output opened, output closed, output escape_waiting, input ready);
	modport sink (input valid, input accepted, input char_valid, input out_char,
		input opened, input closed, input escape_waiting, output ready);
endinterface

`default_nettype wire

>>> rtl/qss_step.sv
// Next-state and result logic for one character of the scanner.
// Depends on qss_pkg.
`default_nettype none

module qss_step import qss_pkg::*; #(
	parameter int MAX_QUOTE_LEN = QSS_MAX_QUOTE_LEN_DEF,
	localparam int CW = $clog2(MAX_QUOTE_LEN + 1)
) (
	input  var qss_cfg_t           cfg,
	input  wire [QSS_CHAR_W-1:0]   ch,
	input  wire                    restart,
	input  wire [CW-1:0]           open_cnt,
	input  wire [CW-1:0]           close_cnt,
	input  wire                    esc_flag,
	output logic [CW-1:0]          open_cnt_nxt,
	output logic [CW-1:0]          close_cnt_nxt,
	output logic                   esc_flag_nxt,
	output qss_result_t            res
);

	function automatic logic [CW-1:0] eff_len(input logic [QSS_LEN_W-1:0] len);
		logic [CW-1:0] r;
		if ({1'b0, len} > 4'(MAX_QUOTE_LEN))
			r = CW'(MAX_QUOTE_LEN);
		else
			r = CW'(len);
		return r;
	endfunction

	// Positions past the stored bytes compare against zero
	function automatic logic [QSS_CHAR_W-1:0] quote_byte(input logic [QSS_CHARS_W-1:0] chars,
		input logic [CW-1:0] pos);
		logic [3:0] p;
		logic [QSS_CHAR_W-1:0] r;
		p = 4'(pos);
		if (p < 4'(QSS_QUOTE_BYTES))
			r = chars[QSS_CHAR_W*p[1:0] +: QSS_CHAR_W];
		else
			r = '0;
		return r;
	endfunction

	logic [CW-1:0] olen, clen;
	logic [CW-1:0] o0, c0;
	logic          e0;
	logic          is_esc;

	always_comb begin
		olen = eff_len(cfg.open_len);
		clen = eff_len(cfg.close_len);
		o0 = restart ? '0 : open_cnt;
		c0 = restart ? '0 : close_cnt;
		e0 = restart ? 1'b0 : esc_flag;
		is_esc = (cfg.escape_code != '0) && !e0 && (ch == cfg.escape_code);

		open_cnt_nxt = o0;
		close_cnt_nxt = c0;
		esc_flag_nxt = e0;
		res = '0;

		priority if (is_esc) begin
			// escape only counts inside the body, before any closing match
			if (o0 == olen && c0 == '0) begin
				esc_flag_nxt = 1'b1;
				res.accepted = 1'b1;
			end
		end else if (o0 != olen) begin
			if (o0 < olen && ch == quote_byte(cfg.open_chars, o0)) begin
				open_cnt_nxt = o0 + CW'(1);
				res.accepted = 1'b1;
			end
		end else if (c0 != clen) begin
			res.accepted = 1'b1;
			if (e0) begin
				res.out_char = qss_translate(ch);
				res.char_valid = 1'b1;
				esc_flag_nxt = 1'b0;
			end else if (c0 < clen && ch == quote_byte(cfg.close_chars, c0)) begin
				close_cnt_nxt = c0 + CW'(1);
			end else begin
				// keep the partial close count; only this character is data
				res.out_char = ch;
				res.char_valid = 1'b1;
			end
		end else begin
			// literal closed: refuse the character
		end

		res.opened = (open_cnt_nxt == olen);
		res.closed = res.opened && (close_cnt_nxt == clen);
		res.escape_waiting = esc_flag_nxt;
	end

endmodule

`default_nettype wire

>>> rtl/quoted_string_scanner.sv
// Quoted string scanner: one result item per character item.
// A character is accepted into the input register and its result is offered from the result register.
// Throughput: one character per cycle while the result side is not stalled; the only loop is the state update.
// The input register can still take one character while a result waits to be taken.
// Reset (arst_n low) clears the match state, both valid flags and restores the
// configuration registers to their defaults. Depends on qss_pkg, qss_if, qss_step.
`default_nettype none

module quoted_string_scanner import qss_pkg::*; #(
	parameter int MAX_QUOTE_LEN = QSS_MAX_QUOTE_LEN_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_we,
	input  wire [QSS_IDX_W-1:0]   cfg_index,
	input  wire [QSS_CHARS_W-1:0] cfg_data,
	qss_in_if.sink                din,
	qss_out_if.source             dout
);

	localparam int CW = $clog2(MAX_QUOTE_LEN + 1);

	qss_cfg_t              cfg_q;
	logic [CW-1:0]         open_cnt_q, close_cnt_q;
	logic                  esc_flag_q;
	logic [CW-1:0]         open_cnt_nxt, close_cnt_nxt;
	logic                  esc_flag_nxt;

	logic                  valid_s1;
	logic [QSS_CHAR_W-1:0] ch_s1;
	logic                  restart_s1;

	logic                  out_valid_q;
	qss_result_t           res_q;
	qss_result_t           res;

	logic                  advance;
	logic                  fire_s1;

	assign advance = !out_valid_q || dout.ready;
	assign fire_s1 = valid_s1 && advance;
	assign din.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.open_chars <= OPEN_CHARS_RST;
			cfg_q.open_len <= OPEN_LEN_RST;
			cfg_q.close_chars <= CLOSE_CHARS_RST;
			cfg_q.close_len <= CLOSE_LEN_RST;
			cfg_q.escape_code <= ESCAPE_CODE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OPEN_CHARS:  cfg_q.open_chars <= cfg_data;
				REG_OPEN_LEN:    cfg_q.open_len <= cfg_data[QSS_LEN_W-1:0];
				REG_CLOSE_CHARS: cfg_q.close_chars <= cfg_data;
				REG_CLOSE_LEN:   cfg_q.close_len <= cfg_data[QSS_LEN_W-1:0];
				REG_ESCAPE_CODE: cfg_q.escape_code <= cfg_data[QSS_CHAR_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (din.ready) begin
			valid_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			ch_s1 <= din.ch;
			restart_s1 <= din.restart;
		end
	end

	qss_step #(
		.MAX_QUOTE_LEN(MAX_QUOTE_LEN)
	) u_step (
		.cfg          (cfg_q),
		.ch           (ch_s1),
		.restart      (restart_s1),
		.open_cnt     (open_cnt_q),
		.close_cnt    (close_cnt_q),
		.esc_flag     (esc_flag_q),
		.open_cnt_nxt (open_cnt_nxt),
		.close_cnt_nxt(close_cnt_nxt),
		.esc_flag_nxt (esc_flag_nxt),
		.res          (res)
	);

	// Scanner state advances once per item leaving the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_cnt_q <= '0;
			close_cnt_q <= '0;
			esc_flag_q <= 1'b0;
		end else if (fire_s1) begin
			open_cnt_q <= open_cnt_nxt;
			close_cnt_q <= close_cnt_nxt;
			esc_flag_q <= esc_flag_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			res_q <= res;
		end
	end

	assign dout.valid = out_valid_q;
	assign dout.accepted = res_q.accepted;
	assign dout.char_valid = res_q.char_valid;
	assign dout.out_char = res_q.out_char;
	assign dout.opened = res_q.opened;
	assign dout.closed = res_q.closed;
	assign dout.escape_waiting = res_q.escape_waiting;

endmodule

`default_nettype wire

>>> rtl/qss_checker.sv
// Port-level checks for the quoted string scanner result channel.
// Bound to quoted_string_scanner; depends on nothing else.
`default_nettype none

module qss_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       out_valid,
	input wire       out_ready,
	input wire       accepted,
	input wire       char_valid,
	input wire [7:0] out_char,
	input wire       opened,
	input wire       closed,
	input wire       escape_waiting
);

	// a stalled result item stays valid
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	a_data_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && char_valid |-> accepted && !escape_waiting)
		else $error("data character without acceptance or with pending escape");

	a_closed_opened: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && closed |-> opened)
		else $error("closed reported before opened");

	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !char_valid |-> out_char == 8'd0)
		else $error("out_char nonzero without data");

endmodule

bind quoted_string_scanner qss_checker u_qss_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (dout.valid),
	.out_ready     (dout.ready),
	.accepted      (dout.accepted),
	.char_valid    (dout.char_valid),
	.out_char      (dout.out_char),
	.opened        (dout.opened),
	.closed        (dout.closed),
	.escape_waiting(dout.escape_waiting)
);

`default_nettype wire

>>> sim/tb_quoted_string_scanner.sv
// Testbench for quoted_string_scanner: drives character items, predicts each result
// item in a scoreboard class and checks it. Depends on qss_pkg, qss_if and the RTL.
`default_nettype none

module tb_quoted_string_scanner;
	import qss_pkg::*;

	localparam int MAX_QUOTE = QSS_MAX_QUOTE_LEN_DEF;
	localparam int N_PHASES = 9;
	localparam int PHASE_CHARS = 100;
	localparam logic [4:0] ALL_REGS = 5'b11111;

	class scan_scoreboard;
		qss_cfg_t regs;
		logic [2:0] open_cnt;
		logic [2:0] close_cnt;
		logic esc_pending;
		qss_result_t expected_scans[$];
		int errors;
		int n_results;
		int n_data;
		int n_refused;

		function new();
			regs.open_chars = OPEN_CHARS_RST;
			regs.open_len = OPEN_LEN_RST;
			regs.close_chars = CLOSE_CHARS_RST;
			regs.close_len = CLOSE_LEN_RST;
			regs.escape_code = ESCAPE_CODE_RST;
			open_cnt = '0;
			close_cnt = '0;
			esc_pending = 1'b0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] v);
			case (idx)
				REG_OPEN_CHARS:  regs.open_chars = v;
				REG_OPEN_LEN:    regs.open_len = v[2:0];
				REG_CLOSE_CHARS: regs.close_chars = v;
				REG_CLOSE_LEN:   regs.close_len = v[2:0];
				REG_ESCAPE_CODE: regs.escape_code = v[7:0];
				default: ;
			endcase
		endfunction

		function logic [2:0] clip_len(logic [2:0] l);
			return (l > MAX_QUOTE) ? 3'(MAX_QUOTE) : l;
		endfunction

		function logic [7:0] quote_char(logic [31:0] chars, logic [2:0] pos);
			if (pos >= QSS_QUOTE_BYTES)
				return 8'h00;
			return chars[8*pos +: 8];
		endfunction

		function logic [7:0] unescape(logic [7:0] c);
			case (c)
				CH_N: return CC_LF;
				CH_R: return CC_CR;
				CH_B: return CC_BS;
				CH_T: return CC_HT;
				CH_A: return CC_BEL;
				default: return c;
			endcase
		endfunction

		// Advance the scanner state by one accepted character and queue its result.
		function void scan_char(logic [7:0] c, logic rs);
			logic [2:0] olen;
			logic [2:0] clen;
			qss_result_t r;
			olen = clip_len(regs.open_len);
			clen = clip_len(regs.close_len);
			r = '0;
			if (rs) begin
				open_cnt = '0;
				close_cnt = '0;
				esc_pending = 1'b0;
			end
			if (regs.escape_code != 8'h00 && !esc_pending && c == regs.escape_code) begin
				if (open_cnt == olen && close_cnt == 3'd0) begin
					esc_pending = 1'b1;
					r.accepted = 1'b1;
				end
			end else if (open_cnt != olen) begin
				if (open_cnt < olen && c == quote_char(regs.open_chars, open_cnt)) begin
					open_cnt = open_cnt + 3'd1;
					r.accepted = 1'b1;
				end
			end else if (close_cnt != clen) begin
				r.accepted = 1'b1;
				if (esc_pending) begin
					r.char_valid = 1'b1;
					r.out_char = unescape(c);
					esc_pending = 1'b0;
				end else if (close_cnt < clen && c == quote_char(regs.close_chars, close_cnt)) begin
					close_cnt = close_cnt + 3'd1;
				end else begin
					r.char_valid = 1'b1;
					r.out_char = c;
				end
			end
			r.opened = (open_cnt == olen);
			r.closed = r.opened && (close_cnt == clen);
			r.escape_waiting = esc_pending;
			if (r.char_valid)
				n_data++;
			if (!r.accepted)
				n_refused++;
			expected_scans = {expected_scans, r};
		endfunction

		task report(string what);
			errors++;
			$display("MISMATCH at %0t, result %0d: %s", $time, n_results, what);
		endtask

		task check_result(qss_result_t got);
			qss_result_t want;
			if (expected_scans.size() == 0) begin
				report($sformatf("result item with nothing expected: %p", got));
				return;
			end
			want = expected_scans.pop_front();
			if (got.accepted !== want.accepted)
				report($sformatf("accepted %b, want %b", got.accepted, want.accepted));
			if (got.char_valid !== want.char_valid)
				report($sformatf("char_valid %b, want %b", got.char_valid, want.char_valid));
			if (got.out_char !== want.out_char)
				report($sformatf("out_char %h, want %h", got.out_char, want.out_char));
			if (got.opened !== want.opened)
				report($sformatf("opened %b, want %b", got.opened, want.opened));
			if (got.closed !== want.closed)
				report($sformatf("closed %b, want %b", got.closed, want.closed));
			if (got.escape_waiting !== want.escape_waiting)
				report($sformatf("escape_waiting %b, want %b",
					got.escape_waiting, want.escape_waiting));
			n_results++;
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [QSS_IDX_W-1:0] cfg_index;
	logic [QSS_CHARS_W-1:0] cfg_data;

	qss_in_if din_bus();
	qss_out_if dout_bus();

	scan_scoreboard sb = new();
	int src_idle_pct;
	int sink_idle_pct;
	int chars_sent;
	int n_settings;
	logic restart_next;

	quoted_string_scanner #(.MAX_QUOTE_LEN(MAX_QUOTE)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.din(din_bus),
		.dout(dout_bus)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		qss_result_t seen;
		if (arst_n && dout_bus.valid && dout_bus.ready) begin
			seen.accepted = dout_bus.accepted;
			seen.char_valid = dout_bus.char_valid;
			seen.out_char = dout_bus.out_char;
			seen.opened = dout_bus.opened;
			seen.closed = dout_bus.closed;
			seen.escape_waiting = dout_bus.escape_waiting;
			sb.check_result(seen);
		end
		dout_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	task automatic send_char(input logic [7:0] c, input logic rs);
		while ($urandom_range(99) < src_idle_pct) begin
			din_bus.valid <= 1'b0;
			@(posedge clk);
		end
		din_bus.valid <= 1'b1;
		din_bus.ch <= c;
		din_bus.restart <= rs;
		do @(posedge clk); while (!din_bus.ready);
		sb.scan_char(c, rs);
		chars_sent++;
	endtask

	task automatic emit(input logic [7:0] c);
		send_char(c, restart_next);
		restart_next = 1'b0;
	endtask

	task automatic send_text(input string s, input logic rs_first);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], rs_first && i == 0);
	endtask

	// Hold off the sender until every queued result item has come back.
	task automatic drain();
		din_bus.valid <= 1'b0;
		while (sb.expected_scans.size() != 0)
			@(posedge clk);
	endtask

	task automatic program_regs(input qss_cfg_t c, input logic [4:0] mask);
		logic [31:0] v [0:4];
		v[REG_OPEN_CHARS] = c.open_chars;
		v[REG_OPEN_LEN] = 32'(c.open_len);
		v[REG_CLOSE_CHARS] = c.close_chars;
		v[REG_CLOSE_LEN] = 32'(c.close_len);
		v[REG_ESCAPE_CODE] = 32'(c.escape_code);
		for (int i = 0; i < 5; i++) begin
			if (mask[i]) begin
				cfg_we <= 1'b1;
				cfg_index <= i[2:0];
				cfg_data <= v[i];
				@(posedge clk);
				sb.write_reg(i[2:0], v[i]);
			end
		end
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	function automatic logic [7:0] body_char();
		return ($urandom_range(9) < 6) ? 8'($urandom_range(32, 126)) : 8'($urandom_range(255));
	endfunction

	function automatic logic [7:0] escaped_char();
		case ($urandom_range(7))
			0: return CH_N;
			1: return CH_R;
			2: return CH_B;
			3: return CH_T;
			4: return CH_A;
			5: return sb.regs.escape_code;
			6: return sb.quote_char(sb.regs.close_chars, 3'd0);
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [31:0] rand_quote();
		logic [31:0] q;
		for (int i = 0; i < QSS_QUOTE_BYTES; i++)
			q[8*i +: 8] = ($urandom_range(9) < 7) ? 8'($urandom_range(33, 126))
				: 8'($urandom_range(255));
		return q;
	endfunction

	function automatic logic [2:0] rand_len();
		return ($urandom_range(4) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 4));
	endfunction

	function automatic qss_cfg_t phase_cfg(int ph);
		qss_cfg_t c;
		c.open_chars = rand_quote();
		c.open_len = rand_len();
		c.close_chars = rand_quote();
		c.close_len = rand_len();
		if ($urandom_range(5) == 0)
			c.escape_code = 8'h00;
		else
			c.escape_code = $urandom_range(1) ? ESCAPE_CODE_RST : 8'($urandom_range(1, 255));
		case (ph)
			0: begin
				c.open_chars = '0;
				c.open_len = 3'd0;
				c.close_chars = '1;
				c.close_len = 3'd4;
				c.escape_code = 8'h00;
			end
			1: begin
				c.open_chars = '1;
				c.open_len = 3'd7;
				c.close_chars = '0;
				c.close_len = 3'd0;
				c.escape_code = 8'hFF;
			end
			6: begin
				c.open_len = 3'd4;
				c.close_len = 3'd7;
			end
			default: ;
		endcase
		return c;
	endfunction

	// Well-formed literal with random body, with an occasional stray or missing part.
	task automatic send_literal();
		logic [2:0] olen;
		logic [2:0] clen;
		int nbody;
		int cut;
		olen = sb.clip_len(sb.regs.open_len);
		clen = sb.clip_len(sb.regs.close_len);
		restart_next = ($urandom_range(9) != 0);
		for (int p = 0; p < olen; p++) begin
			if ($urandom_range(19) == 0)
				emit(8'($urandom_range(255)));
			emit(sb.quote_char(sb.regs.open_chars, 3'(p)));
		end
		nbody = $urandom_range(0, 10);
		for (int k = 0; k < nbody; k++) begin
			case ($urandom_range(9))
				0, 1: begin
					emit(sb.regs.escape_code);
					emit(escaped_char());
				end
				2: begin
					// start the closing quote, then break it
					if (clen > 1) begin
						cut = $urandom_range(1, clen - 1);
						for (int p = 0; p < cut; p++)
							emit(sb.quote_char(sb.regs.close_chars, 3'(p)));
					end
					emit(body_char());
				end
				default: emit(body_char());
			endcase
		end
		if ($urandom_range(9) != 0)
			for (int p = 0; p < clen; p++)
				emit(sb.quote_char(sb.regs.close_chars, 3'(p)));
		repeat ($urandom_range(0, 2))
			emit(body_char());
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 6))
			send_char(8'($urandom_range(255)), $urandom_range(4) == 0);
	endtask

	initial begin
		#(12 * 200_000);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int phase_end;
		qss_cfg_t c;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		din_bus.valid = 1'b0;
		din_bus.ch = '0;
		din_bus.restart = 1'b0;
		dout_bus.ready = 1'b0;
		restart_next = 1'b0;
		src_idle_pct = 33;
		sink_idle_pct = 62;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Default quotes: every translation, escaped quote and escape, then refusals
		send_text("\"\\n\\r\\b\\t\\a\\\"\\\\\\", 1'b1);
		send_char(8'hFF, 1'b0);
		send_text("\"x\\", 1'b0);
		send_text("\\", 1'b1);
		send_char(8'h00, 1'b1);
		drain();

		// Two-character quotes with a broken closing match
		c = sb.regs;
		c.open_chars = 32'h0000_2852;
		c.open_len = 3'd2;
		c.close_chars = 32'h0000_5229;
		c.close_len = 3'd2;
		program_regs(c, ALL_REGS);
		send_text("R()bR", 1'b1);
		drain();
		// Shrink lengths under the live counts
		c.open_len = 3'd1;
		program_regs(c, 5'(1 << REG_OPEN_LEN));
		send_text("z", 1'b0);
		drain();
		c.open_len = 3'd2;
		c.close_len = 3'd1;
		program_regs(c, 5'(1 << REG_OPEN_LEN) | 5'(1 << REG_CLOSE_LEN));
		send_text(")", 1'b0);
		drain();
		// Oversized opening length is clipped to the four stored bytes
		c.open_chars = 32'h4443_4241;
		c.open_len = 3'd7;
		c.close_len = 3'd0;
		program_regs(c, ALL_REGS);
		send_text("ABCD", 1'b1);
		send_char(8'h00, 1'b0);
		send_text("q", 1'b0);
		drain();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			if (ph < 3) begin
				src_idle_pct = 33;
				sink_idle_pct = 62;
			end else if (ph < 6) begin
				src_idle_pct = 62;
				sink_idle_pct = 33;
			end else begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end
			program_regs(phase_cfg(ph), ALL_REGS);
			phase_end = chars_sent + PHASE_CHARS;
			while (chars_sent < phase_end) begin
				if ($urandom_range(9) == 0)
					send_noise();
				else
					send_literal();
			end
			drain();
		end

		repeat (8) @(posedge clk);
		if (sb.expected_scans.size() != 0)
			sb.report($sformatf("%0d result items never arrived", sb.expected_scans.size()));
		$display("Scanned %0d characters under %0d register settings; %0d result items checked.",
			chars_sent, n_settings, sb.n_results);
		$display("Data characters emitted: %0d, characters refused: %0d, mismatches: %0d.",
			sb.n_data, sb.n_refused, sb.errors);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire
